[rtl/cncd_pkg.sv]
// ----------------------------------------------------------------------------
// cncd_pkg
// Types, codes and small helper functions shared by the cpio newc deframer.
// ----------------------------------------------------------------------------
package cncd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } cncd_in_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  out_byte;
    logic [31:0] entry_size;
    logic [31:0] entry_mtime;
    logic [31:0] name_size;
    logic        entry_ready;
    logic [1:0]  archive_status;
  } cncd_out_t;

  // Parser phases; also the byte class reported for a byte in that phase.
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_NAMEPAD = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_DATAPAD = 3'd4;
  localparam logic [2:0] CLS_DISCARD = 3'd5;

  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_END       = 2'd1;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
  localparam logic [1:0] ST_PREMATURE = 2'd3;

  localparam logic [6:0] HDR_LAST     = 7'd109;
  localparam logic [6:0] MAGIC_LEN    = 7'd6;
  localparam logic [6:0] OFS_SIZE     = 7'd54;
  localparam logic [6:0] OFS_MTIME    = 7'd46;
  localparam logic [6:0] OFS_NAMESIZE = 7'd94;
  localparam logic [6:0] HEX_DIGITS   = 7'd8;

  localparam logic [31:0] TRL_LEN    = 32'd10;
  localparam logic [31:0] TRL_LEN_PF = 32'd12;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UF    = 8'h46;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h30;
      3'd1:    ch = 8'h37;
      3'd2:    ch = 8'h30;
      3'd3:    ch = 8'h37;
      3'd4:    ch = 8'h30;
      3'd5:    ch = 8'h31;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h54;
      4'd1:    ch = 8'h52;
      4'd2:    ch = 8'h41;
      4'd3:    ch = 8'h49;
      4'd4:    ch = 8'h4C;
      4'd5:    ch = 8'h45;
      4'd6:    ch = 8'h52;
      4'd7:    ch = 8'h21;
      4'd8:    ch = 8'h21;
      4'd9:    ch = 8'h21;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Does byte b keep a trailer track alive at compared position p?
  function automatic logic track_ok(input logic [31:0] p, input logic [7:0] b);
    logic ok;
    if (p < TRL_LEN) begin
      ok = (b == trailer_char(p[3:0]));
    end else if (p == TRL_LEN) begin
      ok = (b == CH_NUL);
    end else begin
      ok = 1'b1;
    end
    return ok;
  endfunction

  function automatic logic [31:0] hex_step(input logic [31:0] v, input logic [7:0] b);
    logic [7:0] k;
    if (b > CH_UF) begin
      k = 8'd87;
    end else if (b > CH_9) begin
      k = 8'd55;
    end else begin
      k = 8'd48;
    end
    return {v[27:0], 4'h0} + {24'h0, b} - {24'h0, k};
  endfunction

endpackage

[rtl/cncd_parse.sv]
// ----------------------------------------------------------------------------
// cncd_parse
// Parser state and its single-pass update for one archive byte per step.
// ----------------------------------------------------------------------------
module cncd_parse
  import cncd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  cncd_in_t  item,
  output cncd_out_t result
);

  logic [2:0]  phase, phase_next;
  logic [6:0]  header_count, header_count_next;
  logic [31:0] size_value, size_value_next;
  logic [31:0] mtime_value, mtime_value_next;
  logic [31:0] name_length, name_length_next;
  logic [31:0] region_count, region_count_next;
  logic [1:0]  pad_left, pad_left_next;
  logic [1:0]  trailer_match, trailer_match_next;
  logic        magic_ok, magic_ok_next;
  logic [1:0]  stop_status, stop_status_next;

  logic [7:0]  b;
  logic [31:0] rc_inc;
  logic [2:0]  cls;
  logic        ready_flag;
  logic        finish;
  logic [1:0]  tm;
  logic [1:0]  tm_fin;
  logic        mok;
  logic [1:0]  pad_dec;
  logic [1:0]  npad;
  logic [1:0]  dpad;
  logic        hit_plain;
  logic        hit_prefix;

  assign b       = item.data_byte;
  assign rc_inc  = region_count + 32'd1;
  assign pad_dec = pad_left - 2'd1;
  assign npad    = 2'd0 - (name_length[1:0] + 2'd2);
  assign dpad    = 2'd0 - size_value[1:0];

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    size_value_next    = size_value;
    mtime_value_next   = mtime_value;
    name_length_next   = name_length;
    region_count_next  = region_count;
    pad_left_next      = pad_left;
    trailer_match_next = trailer_match;
    magic_ok_next      = magic_ok;
    stop_status_next   = stop_status;
    cls        = CLS_DISCARD;
    ready_flag = 1'b0;
    finish     = 1'b0;
    tm         = trailer_match;
    tm_fin     = trailer_match;
    mok        = magic_ok;
    hit_plain  = 1'b0;
    hit_prefix = 1'b0;
    if (stop_status != ST_RUN) begin
      cls = CLS_DISCARD;
    end else if (item.end_of_input) begin
      stop_status_next = (phase == PH_HEADER) ? ST_END : ST_PREMATURE;
    end else begin
      cls = phase;
      case (phase)
        PH_HEADER: begin
          if (header_count == 7'd0) begin
            mok = 1'b1;
          end
          if (header_count < MAGIC_LEN && b != magic_char(header_count[2:0])) begin
            mok = 1'b0;
          end
          magic_ok_next = mok;
          if (header_count >= OFS_SIZE && header_count < OFS_SIZE + HEX_DIGITS) begin
            size_value_next = hex_step(size_value, b);
          end
          if (header_count >= OFS_MTIME && header_count < OFS_MTIME + HEX_DIGITS) begin
            mtime_value_next = hex_step(mtime_value, b);
          end
          if (header_count >= OFS_NAMESIZE &&
              header_count < OFS_NAMESIZE + HEX_DIGITS) begin
            name_length_next = hex_step(name_length, b);
          end
          if (header_count == HDR_LAST) begin
            header_count_next = 7'd0;
            if (!mok) begin
              stop_status_next = ST_BAD_MAGIC;
            end else begin
              region_count_next  = 32'd0;
              trailer_match_next = 2'b11;
              if (name_length_next != 32'd0) begin
                phase_next = PH_NAME;
              end else begin
                phase_next    = PH_NAMEPAD;
                pad_left_next = 2'd2;
              end
            end
          end else begin
            header_count_next = header_count + 7'd1;
          end
        end
        PH_NAME: begin
          if (!track_ok(region_count, b)) begin
            tm[0] = 1'b0;
          end
          if (region_count == 32'd0) begin
            if (b != CH_DOT) begin
              tm[1] = 1'b0;
            end
          end else if (region_count == 32'd1) begin
            if (b != CH_SLASH) begin
              tm[1] = 1'b0;
            end
          end else if (!track_ok(region_count - 32'd2, b)) begin
            tm[1] = 1'b0;
          end
          trailer_match_next = tm;
          region_count_next  = rc_inc;
          if (rc_inc == name_length) begin
            if (npad != 2'd0) begin
              phase_next    = PH_NAMEPAD;
              pad_left_next = npad;
            end else begin
              finish = 1'b1;
              tm_fin = tm;
            end
          end
        end
        PH_NAMEPAD: begin
          pad_left_next = pad_dec;
          if (pad_dec == 2'd0) begin
            finish = 1'b1;
          end
        end
        PH_DATA: begin
          region_count_next = rc_inc;
          if (rc_inc == size_value) begin
            if (dpad != 2'd0) begin
              phase_next    = PH_DATAPAD;
              pad_left_next = dpad;
            end else begin
              phase_next        = PH_HEADER;
              header_count_next = 7'd0;
            end
          end
        end
        PH_DATAPAD: begin
          pad_left_next = pad_dec;
          if (pad_dec == 2'd0) begin
            phase_next        = PH_HEADER;
            header_count_next = 7'd0;
          end
        end
        default: begin
          phase_next        = PH_HEADER;
          header_count_next = 7'd0;
        end
      endcase
      if (finish) begin
        hit_plain  = tm_fin[0] && (name_length >= TRL_LEN);
        hit_prefix = tm_fin[1] && (name_length >= TRL_LEN_PF);
        if (hit_plain || hit_prefix) begin
          stop_status_next = ST_END;
        end else begin
          ready_flag        = 1'b1;
          region_count_next = 32'd0;
          if (size_value != 32'd0) begin
            phase_next = PH_DATA;
          end else begin
            phase_next        = PH_HEADER;
            header_count_next = 7'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_count  <= 7'd0;
      size_value    <= 32'd0;
      mtime_value   <= 32'd0;
      name_length   <= 32'd0;
      region_count  <= 32'd0;
      pad_left      <= 2'd0;
      trailer_match <= 2'b11;
      magic_ok      <= 1'b1;
      stop_status   <= ST_RUN;
    end else if (step) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      size_value    <= size_value_next;
      mtime_value   <= mtime_value_next;
      name_length   <= name_length_next;
      region_count  <= region_count_next;
      pad_left      <= pad_left_next;
      trailer_match <= trailer_match_next;
      magic_ok      <= magic_ok_next;
      stop_status   <= stop_status_next;
    end
  end

  always_comb begin
    result.byte_class     = cls;
    result.out_byte       = item.end_of_input ? 8'h00 : b;
    result.entry_size     = size_value_next;
    result.entry_mtime    = mtime_value_next;
    result.name_size      = name_length_next;
    result.entry_ready    = ready_flag;
    result.archive_status = stop_status_next;
  end

endmodule

[rtl/cpio_newc_stream_deframer.sv]
// ----------------------------------------------------------------------------
// cpio_newc_stream_deframer
// Byte-stream deframer for cpio newc archives.
//
// Requests on the item channel carry one archive byte, or an end-of-input
// mark. For each request one result comes out on the result channel: the
// byte's class, the byte itself, the decoded size, mtime and name size of
// the current entry, an entry-ready pulse and the archive status.
// Both channels use valid/ready; a request is taken when both are high.
// A request waits in the input register, and the parser update then loads the
// result register once that register is free or its result is being taken.
// Throughput is one request per cycle while the receiver does not stall; the
// parser handles one byte per cycle with a 32-bit hex digit shift, add and
// subtract.
// Reset clears the parser to the start of a header with status running.
// When the receiver stalls, the result register holds, the input register
// fills, and item_ready drops until the result is taken. Once the status
// is not running, every further request yields a discarded result.
// ----------------------------------------------------------------------------
module cpio_newc_stream_deframer
  import cncd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  cncd_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output cncd_out_t result
);

  logic      hold_valid;
  cncd_in_t  hold_item;
  logic      step;
  cncd_out_t parse_result;

  assign step       = hold_valid && (!result_valid || result_ready);
  assign item_ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      hold_item <= item;
    end
  end

  cncd_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (hold_item),
    .result (parse_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= parse_result;
    end
  end

endmodule
